// ===== rtl/srov_pkg.sv =====
// Package with shared types and codes for the stable rank block.
package srov_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOLOAD = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic [7:0]  index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [7:0] rank;
  } out_word_t;

  // Maps a double bit pattern to an unsigned key with the same numeric order.
  function automatic logic [63:0] order_key(input logic [63:0] bits);
    logic [62:0] mag;
    mag = bits[62:0];
    if (mag > 63'h7FF0000000000000)  return 64'hFFFFFFFFFFFFFFFF;
    else if (mag == 63'd0)           return 64'h8000000000000000;
    else if (bits[63])               return ~bits;
    else                             return {1'b1, bits[62:0]};
  endfunction

endpackage

// ===== rtl/srov_cmp.sv =====
// Shared compare unit: one stored entry against the new key per cycle.
module srov_cmp import srov_pkg::*; #(
  parameter int RW = 12
) (
  input  logic [63:0]   new_key,
  input  logic [63:0]   old_value,
  input  logic [RW-1:0] old_rank,
  output logic          le,
  output logic [RW-1:0] bumped_rank
);
  // A stored value at or below the new one counts; others move up.
  assign le          = order_key(old_value) <= new_key;
  assign bumped_rank = old_rank + RW'(1);
endmodule

// ===== rtl/stable_rank_of_values_core.sv =====
// Top level of the stable rank block: store, sequencer and result register.
//
//   Channel | Ports                       | Word
//   input   | in_valid, in_stall, in_word   | op, value, index
//   output  | out_valid, out_stall, out_word| status, slot, rank
//
// An append reads, compares and updates one entry of the store per cycle over
// the shared compare unit.
// Read, clear and full append pass only through the read and output states.
// Reset clears the fill count and the sequencer; the stores need no clearing.
// The block takes no word while it works or while a result is held on out_valid.
module stable_rank_of_values_core import srov_pkg::*; #(
  parameter int MAX_ITEMS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int RW = AW;
  localparam int XW = (CW > 8) ? CW : 8;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SCAN = 5'b00100,
    S_WR   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  logic [63:0]   val_mem [MAX_ITEMS];
  logic [RW-1:0] rank_mem [MAX_ITEMS];

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [AW-1:0] ptr_r;
  logic [CW-1:0] seen_r;
  logic [RW-1:0] acc_r;
  logic [63:0]   key_r, value_r;
  logic [1:0]    op_r;
  logic [7:0]    index_r;
  logic          full_r;
  logic [63:0]   vq_r;
  logic [RW-1:0] rq_r;
  logic          out_valid_r;
  out_word_t     out_r, out_nxt;

  logic          le;
  logic [RW-1:0] bumped;
  logic          accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  srov_cmp #(.RW(RW)) u_cmp (
    .new_key(key_r), .old_value(vq_r), .old_rank(rq_r),
    .le(le), .bumped_rank(bumped)
  );

  // Registered reads at the pointer.
  always_ff @(posedge clk) begin
    vq_r <= val_mem[ptr_r];
    rq_r <= rank_mem[ptr_r];
  end

  // Single write port: bump during scan, new entry at the end.
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && !le) begin
      rank_mem[AW'(seen_r)] <= bumped;
    end else if (state_r == S_WR) begin
      val_mem[AW'(count_r)]  <= value_r;
      rank_mem[AW'(count_r)] <= acc_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_word.op != OP_NONE) state_nxt = S_RD;
      S_RD: begin
        if (op_r == OP_APPEND && count_r < CW'(MAX_ITEMS) && count_r != '0)
          state_nxt = S_SCAN;
        else if (op_r == OP_APPEND && count_r == '0)
          state_nxt = S_WR;
        else
          state_nxt = S_OUT;
      end
      S_SCAN: if (seen_r + CW'(1) == count_r) state_nxt = S_WR;
      S_WR:   state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT) begin
        out_valid_r <= 1'b1;
        if (op_r == OP_CLEAR) count_r <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_WR) count_r <= count_r + CW'(1);
    end
  end

  // Result word; the full flag is taken before the append bumps the count.
  always_comb begin
    out_nxt = '0;
    out_nxt.status = ST_OK;
    unique case (op_r)
      OP_APPEND: begin
        if (full_r) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.slot = 8'(count_r - CW'(1));
          out_nxt.rank = 8'(acc_r);
        end
      end
      OP_READ: begin
        out_nxt.slot = index_r;
        if (XW'(index_r) >= XW'(count_r))
          out_nxt.status = ST_NOLOAD;
        else
          out_nxt.rank = 8'(rq_r);
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      op_r    <= in_word.op;
      value_r <= in_word.value;
      key_r   <= order_key(in_word.value);
      index_r <= in_word.index;
      ptr_r   <= (in_word.op == OP_READ) ? AW'(in_word.index) : '0;
      seen_r  <= '0;
      acc_r   <= '0;
    end else if (state_r == S_RD) begin
      ptr_r  <= AW'(1);
      full_r <= (count_r == CW'(MAX_ITEMS));
    end else if (state_r == S_SCAN) begin
      ptr_r  <= ptr_r + AW'(1);
      seen_r <= seen_r + CW'(1);
      if (le) acc_r <= acc_r + RW'(1);
    end
    // Result captured in the output state.
    if (state_r == S_OUT) out_r <= out_nxt;
  end
endmodule

// ===== rtl/srov_checker.sv =====
// Port checker for the stable rank block, with its bind.
module srov_checker import srov_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("held");
  // No word taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("busy");
  // An accepted word with a real operation blocks the next cycle.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.op != OP_NONE |=> in_stall) else $error("seq");
  // Status codes stay in range.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != ST_RSVD) else $error("status");
endmodule

bind stable_rank_of_values_core srov_checker u_chk (.*);
